// File: rtl/bitmap_page_allocator_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap page allocator
// Shared property wrappers, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bpa_pkg.sv
// ---------------------------------------------------------------------------
// bpa_pkg
// Types, constants and helpers for the bitmap page allocator.
// ---------------------------------------------------------------------------
package bpa_pkg;

  // Map geometry
  localparam int PAGE_COUNT_DEF = 1024;
  localparam int WORD_BITS      = 64;
  localparam int BIT_W          = $clog2(WORD_BITS);

  // Fixed field widths of the request and result
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int IN_DW   = 16;
  localparam int OUT_DW  = 24;

  // Request commands; code 3 is unused and does nothing
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CHECK = 2'd2
  } cmd_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RESP
  } state_t;

  // Result of a first-zero search over one map word
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } ffz_t;

  // Lowest clear bit of a map word
  function automatic ffz_t find_first_zero(input logic [WORD_BITS-1:0] w);
    ffz_t r;
    r.found = 1'b0;
    r.pos   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r.found = 1'b1;
        r.pos   = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/bitmap_page_allocator.sv
// ---------------------------------------------------------------------------
// bitmap_page_allocator
// Next-fit page allocator: one bit per page in a word-wide map memory, a
// count of pages in use and a hint that names a free page.
// ---------------------------------------------------------------------------
//  channel | ports                        | contents
//  --------+------------------------------+-----------------------------------
//  in      | in_tvalid/in_tready/tuser/   | tuser: command; tdata: page_index
//          | tdata                        |
//  out     | out_tvalid/out_tready/tdata  | success, granted_page, pages_in_use
//
//  After reset the map is swept to zero, one 64-bit word a cycle; no request
//  is taken meanwhile.
//  Free, check and a failing allocate pass from the idle state through exec
//  to resp, which loads the result into the output register. An allocate that
//  finds no free page above the hint in its word reads further map words one
//  by one in the scan state, wrapping, bound by the single map read port.
//  One request is in flight at a time; a held result stalls only the next one.
// ---------------------------------------------------------------------------
module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CMD_W-1:0]  in_tuser,   // [1:0] command
  input  logic [IN_DW-1:0]  in_tdata,   // [9:0] page_index, [15:10] zero
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata   // [0] success, [10:1] granted_page,
                                        // [21:11] pages_in_use, [23:22] zero
);

  localparam int WB     = WORD_BITS;
  localparam int WORDS  = (PAGE_COUNT + WB - 1) / WB;
  localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW     = $clog2(PAGE_COUNT);
  localparam int CW     = $clog2(PAGE_COUNT + 1);
  localparam int EW     = PW + BIT_W + AW;
  localparam int TAIL   = PAGE_COUNT - (WORDS - 1) * WB;
  // Bits of the last word beyond the page total read as used
  localparam logic [WB-1:0] TAIL_MASK = ~((WB'(1) << TAIL) - WB'(1));

  // Page to word address and bit position
  function automatic logic [AW-1:0] word_of(input logic [PW-1:0] p);
    logic [EW-1:0] e;
    e = EW'(p);
    return e[BIT_W +: AW];
  endfunction

  function automatic logic [BIT_W-1:0] bit_of(input logic [PW-1:0] p);
    logic [EW-1:0] e;
    e = EW'(p);
    return e[BIT_W-1:0];
  endfunction

  function automatic logic [AW-1:0] next_word(input logic [AW-1:0] a);
    return (a == AW'(WORDS - 1)) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [WB-1:0] tail_of(input logic [AW-1:0] a);
    return (a == AW'(WORDS - 1)) ? TAIL_MASK : '0;
  endfunction

  // Map memory
  logic [WB-1:0] map_mem [WORDS];
  logic [WB-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [WB-1:0] wr_data;

  // Control and payload registers
  state_t           state_r,     state_nxt;
  logic [AW-1:0]    clr_addr_r,  clr_addr_nxt;
  logic [CMD_W-1:0] cmd_r,       cmd_nxt;
  logic [IDX_W-1:0] idx_r,       idx_nxt;
  logic [PW-1:0]    page_r,      page_nxt;
  logic [PW-1:0]    hint_r,      hint_nxt;
  logic [CW-1:0]    count_r,     count_nxt;
  logic [AW-1:0]    scan_addr_r, scan_addr_nxt;
  logic [AW-1:0]    wb_addr_r,   wb_addr_nxt;
  logic [WB-1:0]    wb_data_r,   wb_data_nxt;
  logic             res_ok_r,    res_ok_nxt;
  logic [PW-1:0]    res_grant_r, res_grant_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r,    out_ok_nxt;
  logic [IDX_W-1:0] out_grant_r, out_grant_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;

  // Combinational helpers
  logic [AW-1:0]    page_word;
  logic [BIT_W-1:0] page_bit;
  logic [WB-1:0]    page_onehot;
  logic [WB-1:0]    mod_word;
  logic [WB-1:0]    cand_word;
  logic [WB-1:0]    scan_word;
  ffz_t             hit;
  logic             idx_in_range;
  logic [AW-1:0]    in_word;
  logic [PW-1:0]    in_page;

  // Map memory: registered read, one write port
  always_ff @(posedge clk) begin
    rd_data_r <= map_mem[rd_addr];
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      hint_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      hint_r      <= hint_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    idx_r       <= idx_nxt;
    page_r      <= page_nxt;
    scan_addr_r <= scan_addr_nxt;
    wb_addr_r   <= wb_addr_nxt;
    wb_data_r   <= wb_data_nxt;
    res_ok_r    <= res_ok_nxt;
    res_grant_r <= res_grant_nxt;
    out_ok_r    <= out_ok_nxt;
    out_grant_r <= out_grant_nxt;
    out_count_r <= out_count_nxt;
  end

  // Address decode of the stored and incoming page
  always_comb begin
    page_word    = word_of(page_r);
    page_bit     = bit_of(page_r);
    page_onehot  = WB'(1) << page_bit;
    idx_in_range = (32'(idx_r) < 32'(PAGE_COUNT));
    in_page      = PW'(in_tdata[IDX_W-1:0]);
    in_word      = word_of(in_page);
    if (32'(in_word) >= 32'(WORDS)) begin
      in_word = '0;
    end
  end

  // Next state, memory access and result
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    page_nxt      = page_r;
    hint_nxt      = hint_r;
    count_nxt     = count_r;
    scan_addr_nxt = scan_addr_r;
    wb_addr_nxt   = wb_addr_r;
    wb_data_nxt   = wb_data_r;
    res_ok_nxt    = res_ok_r;
    res_grant_nxt = res_grant_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_ok_nxt    = out_ok_r;
    out_grant_nxt = out_grant_r;
    out_count_nxt = out_count_r;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = page_word;
    wr_data       = '0;
    in_tready     = 1'b0;
    mod_word      = rd_data_r | page_onehot;
    cand_word     = '0;
    scan_word     = (scan_addr_r == wb_addr_r) ? wb_data_r : rd_data_r;
    hit           = '0;

    unique case (state_r)
      // Sweep the map to all free
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        if (clr_addr_r == AW'(WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end

      // Take a request and read the word holding its page
      ST_IDLE: begin
        in_tready = 1'b1;
        rd_addr   = (in_tuser == CMD_ALLOC) ? word_of(hint_r) : in_word;
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          idx_nxt   = in_tdata[IDX_W-1:0];
          page_nxt  = (in_tuser == CMD_ALLOC) ? hint_r : in_page;
          state_nxt = ST_EXEC;
        end
      end

      // Read-modify-write of the page's word; a check only reads it
      ST_EXEC: begin
        res_ok_nxt    = 1'b0;
        res_grant_nxt = '0;
        state_nxt     = ST_RESP;
        unique case (cmd_r)
          CMD_ALLOC: begin
            if (count_r != CW'(PAGE_COUNT)) begin
              wr_en         = 1'b1;
              wr_data       = mod_word;
              wb_addr_nxt   = page_word;
              wb_data_nxt   = mod_word;
              res_ok_nxt    = 1'b1;
              res_grant_nxt = page_r;
              count_nxt     = count_r + CW'(1);
              if (count_r != CW'(PAGE_COUNT - 1)) begin
                // look for the next free page above the hint in this word
                cand_word = mod_word | ((WB'(1) << page_bit) - WB'(1))
                            | tail_of(page_word);
                hit       = find_first_zero(cand_word);
                if (hit.found) begin
                  hint_nxt = PW'({page_word, hit.pos});
                end else begin
                  rd_addr       = next_word(page_word);
                  scan_addr_nxt = next_word(page_word);
                  state_nxt     = ST_SCAN;
                end
              end
            end
          end
          CMD_FREE: begin
            if (idx_in_range && rd_data_r[page_bit]) begin
              wr_en      = 1'b1;
              wr_data    = rd_data_r & ~page_onehot;
              hint_nxt   = page_r;
              count_nxt  = count_r - CW'(1);
              res_ok_nxt = 1'b1;
            end
          end
          CMD_CHECK: begin
            res_ok_nxt = idx_in_range && !rd_data_r[page_bit];
          end
          default: begin
          end
        endcase
      end

      // Walk the map word by word, wrapping, until a free page turns up
      ST_SCAN: begin
        cand_word = scan_word | tail_of(scan_addr_r);
        hit       = find_first_zero(cand_word);
        if (hit.found) begin
          hint_nxt  = PW'({scan_addr_r, hit.pos});
          state_nxt = ST_RESP;
        end else begin
          rd_addr       = next_word(scan_addr_r);
          scan_addr_nxt = next_word(scan_addr_r);
        end
      end

      // Hand the result to the output register once it is free
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_grant_nxt = IDX_W'(res_grant_r);
          out_count_nxt = CNT_W'(count_r);
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DW - 1 - IDX_W - CNT_W)'(0), out_count_r, out_grant_r, out_ok_r};

endmodule

// File: rtl/bpa_checker.sv
// ---------------------------------------------------------------------------
// bpa_checker
// Port-level checks for the bitmap page allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "bitmap_page_allocator_defines.svh"

module bpa_checker
  import bpa_pkg::*;
#(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata
);

  // A stalled result stays offered
  `BPA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped")

  // One request at a time: no request is taken right after another
  `BPA_ASSERT_NEXT(a_one_inflight, in_tvalid && in_tready, !in_tready, "taken while busy")

  // A failed request never reports a granted page
  `BPA_ASSERT_NOW(a_grant_zero, out_tvalid && !out_tdata[0], out_tdata[10:1] == '0, "bad grant")

  // The page count never exceeds the page total
  `BPA_ASSERT_NOW(a_count_max, out_tvalid, 32'(out_tdata[21:11]) <= PAGE_COUNT, "count over total")

endmodule

bind bitmap_page_allocator bpa_checker #(.PAGE_COUNT(PAGE_COUNT)) u_bpa_checker (.*);

// File: tb/tb_bitmap_page_allocator.sv
// ---------------------------------------------------------------------------
// tb_bitmap_page_allocator
// Self-checking bench for the next-fit page allocator. A short table of
// directed requests comes first, then random allocate/free/check/unused traffic and
// a closing churn phase with no idling. Every result is compared field by
// field with a behavioural copy of the allocator, or with the value written
// in the table.
// ---------------------------------------------------------------------------
module tb_bitmap_page_allocator;
  import bpa_pkg::*;

  localparam int PAGES          = PAGE_COUNT_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 60;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 40;

  // Command code with no operation behind it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic             success;
    logic [IDX_W-1:0] granted;
    logic [CNT_W-1:0] in_use;
  } page_result_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    bit               pinned;
    page_result_t     want;
  } plan_row_t;

  localparam int PLAN_ROWS = 20;

  // Directed requests; pinned rows carry the result written out by hand
  plan_row_t plan [PLAN_ROWS] = '{
    '{CMD_CHECK,  10'd0,    1'b1, '{1'b1, 10'd0, 11'd0}},
    '{CMD_FREE,   10'd0,    1'b1, '{1'b0, 10'd0, 11'd0}},
    '{CMD_CHECK,  10'd1023, 1'b1, '{1'b1, 10'd0, 11'd0}},
    '{CMD_FREE,   10'd1023, 1'b1, '{1'b0, 10'd0, 11'd0}},
    '{CMD_UNUSED, 10'd1023, 1'b1, '{1'b0, 10'd0, 11'd0}},
    '{CMD_ALLOC,  10'd0,    1'b1, '{1'b1, 10'd0, 11'd1}},
    '{CMD_ALLOC,  10'd1023, 1'b1, '{1'b1, 10'd1, 11'd2}},
    '{CMD_CHECK,  10'd0,    1'b1, '{1'b0, 10'd0, 11'd2}},
    '{CMD_FREE,   10'd0,    1'b1, '{1'b1, 10'd0, 11'd1}},
    '{CMD_ALLOC,  10'h155,  1'b1, '{1'b1, 10'd0, 11'd2}},
    '{CMD_ALLOC,  10'h2AA,  1'b0, '{1'b0, 10'd0, 11'd0}},
    '{CMD_FREE,   10'd1,    1'b0, '{1'b0, 10'd0, 11'd0}},
    '{CMD_ALLOC,  10'd0,    1'b0, '{1'b0, 10'd0, 11'd0}},
    '{CMD_UNUSED, 10'h2AA,  1'b1, '{1'b0, 10'd0, 11'd3}},
    '{CMD_CHECK,  10'd3,    1'b0, '{1'b0, 10'd0, 11'd0}},
    '{CMD_CHECK,  10'd2,    1'b0, '{1'b0, 10'd0, 11'd0}},
    '{CMD_FREE,   10'd2,    1'b0, '{1'b0, 10'd0, 11'd0}},
    '{CMD_ALLOC,  10'h155,  1'b0, '{1'b0, 10'd0, 11'd0}},
    '{CMD_FREE,   10'd1023, 1'b1, '{1'b0, 10'd0, 11'd3}},
    '{CMD_CHECK,  10'h155,  1'b0, '{1'b0, 10'd0, 11'd0}}
  };

  logic clk = 1'b0;
  logic rst_n;

  logic              in_tvalid;
  logic              in_tready;
  logic [CMD_W-1:0]  in_tuser;
  logic [IN_DW-1:0]  in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;

  // Hand-written expectation travelling with the request on the bus
  logic         pin_valid;
  page_result_t pin_result;

  // Allocator copy: map, hint and count
  bit [PAGES-1:0]   page_map = '0;
  logic [IDX_W-1:0] next_free = '0;
  int               pages_used = 0;

  page_result_t outcome_q [$];

  bit steady        = 1'b0;
  bit hold_request  = 1'b0;
  int quiet_cycles  = 0;
  int mismatches    = 0;
  int results_seen  = 0;
  int n_alloc       = 0;
  int n_refused     = 0;
  int n_free        = 0;
  int n_check       = 0;
  int n_unused      = 0;

  bitmap_page_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Next-fit behaviour: applies one request to the map and returns its result
  function automatic page_result_t page_op_outcome(input logic [CMD_W-1:0] cmd,
                                                   input logic [IDX_W-1:0] idx);
    page_result_t r;
    int p;
    r = '{success: 1'b0, granted: '0, in_use: '0};
    case (cmd)
      CMD_ALLOC: begin
        if (pages_used < PAGES) begin
          r.success = 1'b1;
          r.granted = next_free;
          page_map[next_free] = 1'b1;
          pages_used++;
          // hint moves to the first free page at or after it, wrapping
          if (pages_used < PAGES) begin
            for (int i = 0; i < PAGES; i++) begin
              p = (int'(next_free) + i) % PAGES;
              if (!page_map[p]) begin
                next_free = IDX_W'(p);
                break;
              end
            end
          end
        end
      end
      CMD_FREE: begin
        if (int'(idx) < PAGES && page_map[idx]) begin
          page_map[idx] = 1'b0;
          next_free = idx;
          pages_used--;
          r.success = 1'b1;
        end
      end
      CMD_CHECK: r.success = int'(idx) < PAGES && !page_map[idx];
      default: ;
    endcase
    r.in_use = CNT_W'(pages_used);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t  %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Request and result monitor, plus the idle counter for the watchdog
  always @(posedge clk) begin
    page_result_t want;
    page_result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        want = page_op_outcome(in_tuser, in_tdata[IDX_W-1:0]);
        case (in_tuser)
          CMD_ALLOC: begin
            n_alloc++;
            if (!want.success) n_refused++;
          end
          CMD_FREE:  n_free++;
          CMD_CHECK: n_check++;
          default:   n_unused++;
        endcase
        if (pin_valid) want = pin_result;
        outcome_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.success = out_tdata[0];
        got.granted = out_tdata[IDX_W:1];
        got.in_use  = out_tdata[IDX_W+CNT_W:IDX_W+1];
        if (outcome_q.size() == 0) begin
          report_mismatch("result with no request pending", int'(got.granted), 0);
        end else begin
          want = outcome_q.pop_front();
          if (got.success !== want.success)
            report_mismatch("success", int'(got.success), int'(want.success));
          if (got.granted !== want.granted)
            report_mismatch("granted_page", int'(got.granted), int'(want.granted));
          if (got.in_use !== want.in_use)
            report_mismatch("pages_in_use", int'(got.in_use), int'(want.in_use));
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
  end

  // Watchdog: no handshake on either side for too long
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("watchdog expired, %0d results still outstanding", outcome_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Drives one request from a falling edge and returns on the falling edge
  // after it is taken; valid stays high so back-to-back requests need no dip
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                              input bit pinned, input page_result_t want);
    if (!steady && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tuser   <= cmd;
    in_tdata   <= IN_DW'(idx);
    pin_valid  <= pinned;
    pin_result <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Pauses the sender until every outstanding result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [IDX_W-1:0] random_index();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return IDX_W'($urandom_range(0, PAGES - 1));
    endcase
  endfunction

  // First page in use at or after start, wrapping; start itself if none
  function automatic logic [IDX_W-1:0] used_page_from(input logic [IDX_W-1:0] start);
    int p;
    for (int i = 0; i < PAGES; i++) begin
      p = (int'(start) + i) % PAGES;
      if (page_map[p]) return IDX_W'(p);
    end
    return start;
  endfunction

  // Weighted random request; most frees aim at a page in use
  task automatic send_random(input int alloc_pct, input int free_pct, input int check_pct);
    int roll;
    logic [IDX_W-1:0] idx;
    roll = $urandom_range(0, 99);
    idx  = random_index();
    if (roll < alloc_pct) begin
      send_request(CMD_ALLOC, idx, 1'b0, '0);
    end else if (roll < alloc_pct + free_pct) begin
      if ($urandom_range(0, 4) != 0) idx = used_page_from(idx);
      send_request(CMD_FREE, idx, 1'b0, '0);
    end else if (roll < alloc_pct + free_pct + check_pct) begin
      if ($urandom_range(0, 1) == 0) idx = used_page_from(idx);
      send_request(CMD_CHECK, idx, 1'b0, '0);
    end else begin
      send_request(CMD_UNUSED, idx, 1'b0, '0);
    end
  endtask

  // Stimulus
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = CMD_ALLOC;
    in_tdata   = '0;
    pin_valid  = 1'b0;
    pin_result = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (plan[i]) send_request(plan[i].cmd, plan[i].idx, plan[i].pinned, plan[i].want);
    drain_results();

    // mixed random traffic, with one long receiver hold-off and one pause
    for (int n = 0; n < 250; n++) begin
      if (n == 80) hold_request = 1'b1;
      if (n == 160) drain_results();
      send_random(45, 25, 25);
    end

    // closing churn, no idling on either side
    drain_results();
    steady = 1'b1;
    for (int n = 0; n < 150; n++) send_random(45, 45, 10);

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (outcome_q.size() != 0)
      report_mismatch("results never delivered", 0, outcome_q.size());

    $display("covered %0d allocates (%0d refused on a full map), %0d frees, %0d checks,",
             n_alloc, n_refused, n_free, n_check);
    $display("%0d requests with the unused code; %0d results compared",
             n_unused, results_seen);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
